// ===== hdl/pk7_pkg.sv =====
// Package for the byte to 7-bit packer.
// Holds the job record passed from the front end to the back end and shared constants.
// No dependencies.
package pk7_pkg;

    localparam int SYM_BITS    = 7;
    localparam int BYTE_BITS   = 8;
    localparam int LEFT_BITS   = 6;
    localparam int CNT_BITS    = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_CW    = 2;

    localparam logic [CNT_BITS-1:0] MAX_LEFT = 3'd6;
    localparam logic SYM_MARK = 1'b1;

    // One classified byte: one or two 7-bit symbols and the end of message mark.
    typedef struct packed {
        logic [SYM_BITS-1:0] sym0;
        logic [SYM_BITS-1:0] sym1;
        logic                two;
        logic                eom;
    } pk7_job_t;

endpackage

// ===== hdl/pk7_if.sv =====
// Channel interfaces for the byte to 7-bit packer.
// Byte channel in, symbol channel out; valid/ready handshake. No dependencies.
interface pk7_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface pk7_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       last_symbol;

    modport source (output valid, output symbol, output last_symbol, input ready);
    modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

// ===== hdl/pk7_front.sv =====
// Front end of the byte to 7-bit packer: accepts bytes, keeps the leftover bits
// and turns each byte into a job of one or two symbols. Depends on pk7_pkg.
module pk7_front (
    input  logic              clk,
    input  logic              rst_n,
    pk7_in_if.sink            bytes,
    output logic              push_valid,
    input  logic              push_ready,
    output pk7_pkg::pk7_job_t push_job
);
    import pk7_pkg::*;

    logic [LEFT_BITS-1:0]            leftover_bits_reg, leftover_bits_next;
    logic [CNT_BITS-1:0]             leftover_count_reg, leftover_count_next;
    logic [CNT_BITS-1:0]             cnt;
    logic                            full_two;
    logic [CNT_BITS-1:0]             rem;
    logic [LEFT_BITS+BYTE_BITS-1:0]  acc;
    logic [LEFT_BITS+BYTE_BITS-1:0]  shifted;
    logic [LEFT_BITS:0]              mask;
    logic [LEFT_BITS-1:0]            left;
    logic [SYM_BITS-1:0]             pad;
    logic                            accept;

    assign bytes.ready = push_ready;
    assign push_valid  = bytes.valid;
    assign accept      = bytes.valid && push_ready;

    always_comb
    begin
        cnt      = (leftover_count_reg > MAX_LEFT) ? MAX_LEFT : leftover_count_reg;
        full_two = (cnt == MAX_LEFT);
        rem      = cnt + 3'd1;
        acc      = {leftover_bits_reg, bytes.data_byte};
        shifted  = acc >> rem;
        mask     = (7'd1 << rem) - 7'd1;
        left     = acc[LEFT_BITS-1:0] & mask[LEFT_BITS-1:0];
        pad      = SYM_BITS'({1'b0, left} << (3'd7 - rem));

        push_job.sym0 = full_two ? acc[LEFT_BITS+BYTE_BITS-1:SYM_BITS]
                                 : shifted[SYM_BITS-1:0];
        push_job.sym1 = full_two ? bytes.data_byte[SYM_BITS-1:0] : pad;
        push_job.two  = full_two || bytes.end_of_message;
        push_job.eom  = bytes.end_of_message;

        leftover_bits_next  = leftover_bits_reg;
        leftover_count_next = leftover_count_reg;
        if (accept)
        begin
            if (bytes.end_of_message || full_two)
            begin
                leftover_bits_next  = '0;
                leftover_count_next = '0;
            end
            else
            begin
                leftover_bits_next  = left;
                leftover_count_next = rem;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leftover_bits_reg  <= '0;
            leftover_count_reg <= '0;
        end
        else
        begin
            leftover_bits_reg  <= leftover_bits_next;
            leftover_count_reg <= leftover_count_next;
        end
    end

endmodule

// ===== hdl/pk7_queue.sv =====
// Two-entry job queue between the front end and the back end of the packer.
// Depends on pk7_pkg.
module pk7_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  pk7_pkg::pk7_job_t push_job,
    output logic              pop_valid,
    input  logic              pop_ready,
    output pk7_pkg::pk7_job_t pop_job
);
    import pk7_pkg::*;

    pk7_job_t              entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]   count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QUEUE_CW'(do_push) - QUEUE_CW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/pk7_back.sv =====
// Back end of the packer: takes jobs from the queue and sends their symbols,
// one per cycle while the receiver is ready, through an output register. Depends on pk7_pkg.
module pk7_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  pk7_pkg::pk7_job_t pop_job,
    pk7_out_if.source         symbols
);
    import pk7_pkg::*;

    logic                  out_valid_reg, out_valid_next;
    logic [BYTE_BITS-1:0]  symbol_reg, symbol_next;
    logic                  last_reg, last_next;
    logic                  pend_reg, pend_next;
    logic [SYM_BITS-1:0]   pend_sym_reg, pend_sym_next;
    logic                  pend_last_reg, pend_last_next;
    logic                  load;

    assign symbols.valid       = out_valid_reg;
    assign symbols.symbol      = symbol_reg;
    assign symbols.last_symbol = last_reg;

    // The output register may take a new symbol when it is empty or being drained.
    assign load      = !out_valid_reg || symbols.ready;
    assign pop_ready = load && !pend_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        symbol_next    = symbol_reg;
        last_next      = last_reg;
        pend_next      = pend_reg;
        pend_sym_next  = pend_sym_reg;
        pend_last_next = pend_last_reg;
        if (load)
        begin
            if (pend_reg)
            begin
                out_valid_next = 1'b1;
                symbol_next    = {SYM_MARK, pend_sym_reg};
                last_next      = pend_last_reg;
                pend_next      = 1'b0;
            end
            else if (pop_valid)
            begin
                out_valid_next = 1'b1;
                symbol_next    = {SYM_MARK, pop_job.sym0};
                last_next      = pop_job.eom && !pop_job.two;
                pend_next      = pop_job.two;
                pend_sym_next  = pop_job.sym1;
                pend_last_next = pop_job.eom;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        symbol_reg    <= symbol_next;
        last_reg      <= last_next;
        pend_sym_reg  <= pend_sym_next;
        pend_last_reg <= pend_last_next;
    end

    // A pending second symbol exists only while its first symbol is on display.
    a_pend_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> out_valid_reg)
        else $error("second symbol pending with empty output register");

    // The first symbol of a two-symbol job never closes a message.
    a_pend_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !last_reg)
        else $error("last flag set ahead of a pending symbol");

    // No job is taken from the queue while a second symbol still waits.
    a_no_pop_while_pend: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !pop_ready)
        else $error("queue popped while a symbol is pending");

    // Every symbol shown carries the marker bit.
    a_marker_bit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> symbol_reg[BYTE_BITS-1])
        else $error("symbol shown without marker bit");

endmodule

// ===== hdl/byte_to_7bit_packer.sv =====
// Top level of the byte to 7-bit packer.
// Depends on pk7_pkg, pk7_if, pk7_front, pk7_queue and pk7_back.
//
// Usage:
// The block repacks a message, given as bytes on the "bytes" channel, into
// 7-bit groups sent MSB first on the "symbols" channel. Each symbol has bit 7
// set, so it lies in 128..255. A request on "bytes" carries one data byte and
// an end_of_message flag; a request on "symbols" carries one symbol and a
// last_symbol flag that marks the final symbol of the message.
// Each byte gives one or two symbols. When the message's last byte leaves
// bits over, they are left-aligned and zero-padded into a final symbol.
// Path: the first symbol of a byte is written into the job queue when the byte is
// accepted, then loaded into the output register, from which it is offered.
// Throughput: one symbol per cycle while the receiver is ready, set by the
// single output register; a byte is taken each cycle while the two-entry job
// queue has room.
// When the receiver stalls, the output register holds its symbol, the queue
// fills, and then the byte channel drops ready. Leftover bits are kept in the
// front end, so bytes keep being classified while symbols are still waiting.
// Reset clears the leftover bits, empties the queue and the output register;
// bytes are accepted as soon as reset is released.
module byte_to_7bit_packer (
    input  logic      clk,
    input  logic      rst_n,
    pk7_in_if.sink    bytes,
    pk7_out_if.source symbols
);
    import pk7_pkg::*;

    // Jobs travel from the front end into the queue.
    logic     push_valid;
    logic     push_ready;
    pk7_job_t push_job;

    // Jobs leave the queue towards the back end.
    logic     pop_valid;
    logic     pop_ready;
    pk7_job_t pop_job;

    // The front end splits each byte into its symbols and tracks leftover bits.
    pk7_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    // The queue lets the front end keep accepting bytes while symbols wait.
    pk7_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // The back end sends one symbol per cycle while the receiver is ready, through its output register.
    pk7_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .symbols   (symbols)
    );

endmodule

// ===== dv/tb_byte_to_7bit_packer.sv =====
// Self-checking testbench for byte_to_7bit_packer: drives byte requests, predicts the
// 7-bit symbols in a local bit buffer and checks every symbol request in order.
// Depends on pk7_pkg, pk7_if and the byte_to_7bit_packer RTL.
module tb_byte_to_7bit_packer;

    timeunit 1ns;
    timeprecision 1ps;

    import pk7_pkg::*;

    // The run is stopped by force well beyond the slowest legal run.
    localparam int CYCLE_LIMIT  = 200000;
    // Cycles allowed after the last expected symbol before the final check.
    localparam int SETTLE_CYCLES = 8;
    // Length of the receiver hold-off used to fill the block and stall its input.
    localparam int HOLD_OFF_CYCLES = 80;
    // Number of random bytes sent after the directed part.
    localparam int RANDOM_BYTES = 180;

    // One expected symbol request.
    typedef struct {
        logic [7:0] symbol;
        logic       last_flag;
    } symbol_rec_t;

    logic clk;
    logic rst_n;

    pk7_in_if  bytes_if ();
    pk7_out_if symbols_if ();

    byte_to_7bit_packer uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes_if.sink),
        .symbols (symbols_if.source)
    );

    // Symbols still owed by the block, oldest first.
    symbol_rec_t pending_symbols[$];

    // Bits of the current message not yet packed into a symbol, right-aligned.
    logic [LEFT_BITS-1:0] carry_bits;
    logic [CNT_BITS-1:0]  carry_count;

    int error_count;
    int cycle_count;

    // When set, neither side inserts gaps or stalls, which gives back-to-back stretches.
    bit no_idle;
    // A nonzero value asks the receiver to hold ready low for that many cycles.
    int hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Works out the symbols that one accepted byte request must produce. The byte is
    // appended below the carried bits; while seven or more bits are buffered the oldest
    // seven leave as a symbol with bit 7 set. On the last byte of a message any remaining
    // bits are left-aligned and zero-padded into a closing symbol; if nothing remains,
    // the last symbol of this byte carries the flag instead. The buffer then clears.
    task automatic predict_symbols(input logic [7:0] value, input logic eom);
        logic [LEFT_BITS+BYTE_BITS-1:0] acc;
        int nbits;
        int produced;
        symbol_rec_t rec;
        acc = {carry_bits, value};
        nbits = int'(carry_count) + BYTE_BITS;
        produced = 0;
        while (nbits >= SYM_BITS && produced < 2)
        begin
            nbits -= SYM_BITS;
            rec.symbol = {1'b1, 7'(acc >> nbits)};
            rec.last_flag = 1'b0;
            pending_symbols.push_back(rec);
            produced++;
        end
        acc = acc & ((14'd1 << nbits) - 14'd1);
        if (eom)
        begin
            if (nbits > 0)
            begin
                rec.symbol = {1'b1, 7'(acc << (SYM_BITS - nbits))};
                rec.last_flag = 1'b1;
                pending_symbols.push_back(rec);
            end
            else
            begin
                pending_symbols[$].last_flag = 1'b1;
            end
            carry_bits = '0;
            carry_count = '0;
        end
        else
        begin
            carry_bits = acc[LEFT_BITS-1:0];
            carry_count = nbits[CNT_BITS-1:0];
        end
    endtask

    // Offers one byte request after a random gap and returns at the edge where it is
    // taken. The prediction is made at that edge, so the order of expectations follows
    // the order of acceptance. Valid stays high into the next request when the next
    // gap is zero, so it is assigned only once per time step.
    task automatic send_byte(input logic [7:0] value, input logic eom);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            bytes_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        bytes_if.valid <= 1'b1;
        bytes_if.data_byte <= value;
        bytes_if.end_of_message <= eom;
        do
            @(posedge clk);
        while (!bytes_if.ready);
        predict_symbols(value, eom);
    endtask

    // Lets the block run dry: the sender goes quiet until every owed symbol has
    // arrived, then keeps the clock running so that a stray symbol would still be seen.
    task automatic wait_for_symbols();
        bytes_if.valid <= 1'b0;
        while (pending_symbols.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Messages of a single byte, at the extremes of the byte: one data symbol and a
    // padded closing symbol each, and the buffer must clear between them.
    task automatic test_single_byte_messages();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b1);
        send_byte(8'h01, 1'b1);
        wait_for_symbols();
    endtask

    // Seven bytes fill eight symbols exactly, so the last byte has no leftover and its
    // second symbol must carry the last flag with no padding symbol after it.
    task automatic test_exact_fill_message();
        logic [7:0] pattern[7];
        pattern = '{8'hFF, 8'h00, 8'hAA, 8'h55, 8'h81, 8'h7E, 8'hC3};
        foreach (pattern[i])
            send_byte(pattern[i], i == 6);
        wait_for_symbols();
    endtask

    // Messages that end with leftover bits: six bytes leave the fullest carry of six
    // bits, three bytes leave three. Both close with a padded symbol.
    task automatic test_padded_messages();
        logic [7:0] six_bytes[6];
        logic [7:0] three_bytes[3];
        six_bytes = '{8'h01, 8'h80, 8'hFE, 8'h7F, 8'h33, 8'hCC};
        three_bytes = '{8'hF0, 8'h0F, 8'h99};
        foreach (six_bytes[i])
            send_byte(six_bytes[i], i == 5);
        foreach (three_bytes[i])
            send_byte(three_bytes[i], i == 2);
        wait_for_symbols();
    endtask

    // The receiver holds off for a long stretch while bytes keep coming without gaps,
    // so the output register and job queue fill and the byte channel drops ready.
    task automatic test_output_backpressure();
        no_idle = 1'b1;
        hold_cycles = HOLD_OFF_CYCLES;
        for (int i = 0; i < 12; i++)
            send_byte(8'($urandom), i == 11);
        no_idle = 1'b0;
        wait_for_symbols();
    endtask

    // Random messages of random length with random content. Most are short so that
    // message boundaries fall at every carry count; some are long. Some messages run
    // with no idling on either side.
    task automatic test_random_messages();
        int sent;
        int msg_len;
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 7) == 0)
                msg_len = $urandom_range(20, 30);
            else
                msg_len = $urandom_range(1, 12);
            no_idle = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < msg_len; i++)
                send_byte(8'($urandom), i == msg_len - 1);
            sent += msg_len;
        end
        no_idle = 1'b0;
        wait_for_symbols();
    endtask

    // Receiver: one random stall per symbol request, or a long hold-off on demand.
    // The wait for a handshake also breaks off when a hold-off is asked for, so that
    // the hold starts even while no symbol is on offer.
    initial
    begin
        int stall;
        symbols_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_cycles > 0)
            begin
                stall = hold_cycles;
                hold_cycles = 0;
            end
            else
            begin
                stall = no_idle ? 0 : $urandom_range(0, 10);
            end
            if (stall > 0)
            begin
                symbols_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            symbols_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(symbols_if.valid && symbols_if.ready) && hold_cycles == 0);
        end
    end

    // Checker: every symbol request is matched against the oldest expectation.
    always @(posedge clk)
    begin
        symbol_rec_t exp_rec;
        if (rst_n && symbols_if.valid && symbols_if.ready)
        begin
            if (pending_symbols.size() == 0)
            begin
                $error("unexpected symbol request: symbol %02h last_symbol %0b",
                       symbols_if.symbol, symbols_if.last_symbol);
                error_count++;
            end
            else
            begin
                exp_rec = pending_symbols.pop_front();
                if (symbols_if.symbol !== exp_rec.symbol)
                begin
                    $error("symbol mismatch: expected %02h, actual %02h",
                           exp_rec.symbol, symbols_if.symbol);
                    error_count++;
                end
                if (symbols_if.last_symbol !== exp_rec.last_flag)
                begin
                    $error("last_symbol mismatch: expected %0b, actual %0b",
                           exp_rec.last_flag, symbols_if.last_symbol);
                    error_count++;
                end
            end
        end
    end

    // Main sequence: reset once, then each test in turn, then the verdict.
    initial
    begin
        error_count = 0;
        no_idle = 1'b0;
        hold_cycles = 0;
        carry_bits = '0;
        carry_count = '0;
        rst_n <= 1'b0;
        bytes_if.valid <= 1'b0;
        bytes_if.data_byte <= 8'h00;
        bytes_if.end_of_message <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_byte_messages();
        test_exact_fill_message();
        test_padded_messages();
        test_output_backpressure();
        test_random_messages();

        if (pending_symbols.size() != 0)
        begin
            $error("%0d expected symbols never arrived", pending_symbols.size());
            error_count++;
        end
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/pk7_pkg.sv
hdl/pk7_if.sv
hdl/pk7_front.sv
hdl/pk7_queue.sv
hdl/pk7_back.sv
hdl/byte_to_7bit_packer.sv
dv/tb_byte_to_7bit_packer.sv
